[rtl/lsbp_pkg.sv]
// Package for the LSB-first bit packer: item types, codes and shared constants.
package lsbp_pkg;

  // Field widths of the input and result items.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FWIDTH_W    = 6;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned TOTAL_W     = 22;
  localparam int unsigned CAP_W       = 17;
  localparam int unsigned PEND_W      = 5;
  localparam int unsigned NWP_W       = 17;

  // Default upper bound on the buffer size in words, and the register reset.
  localparam int unsigned MAX_WORDS_DEFAULT = 65536;
  localparam logic [CAP_W-1:0] CAP_RESET    = 17'd256;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALIGN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   field_value;
    logic [FWIDTH_W-1:0] field_width;
    logic [FWIDTH_W-1:0] align_multiple;
  } in_item_t;

  typedef struct packed {
    logic                word_valid;
    logic [WORD_W-1:0]   packed_word;
    logic [POS_W-1:0]    word_position;
    logic                overflow_error;
    logic [TOTAL_W-1:0]  total_bits;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic calc_en;
    logic apply_en;
  } lsbp_cmd_t;

endpackage

[rtl/lsbp_ctrl.sv]
// Controller for the LSB-first bit packer: sequencing and output handshake.
module lsbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lsbp_pkg::lsbp_cmd_t cmd
);
  import lsbp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // A new item enters when idle, or while the current one is being applied.
  assign in_stall = !((state == S_IDLE) || ((state == S_APPLY) && out_free));
  assign accept   = in_valid && !in_stall;

  assign cmd.load_in  = accept;
  assign cmd.calc_en  = (state == S_CALC);
  assign cmd.apply_en = (state == S_APPLY) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CALC;
      end
      S_CALC: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_next = accept ? S_CALC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.apply_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/lsbp_datapath.sv]
// Datapath for the LSB-first bit packer: scratch bits, counters and result register.
module lsbp_datapath #(
  parameter int unsigned MAX_WORDS = lsbp_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsbp_pkg::lsbp_cmd_t           cmd,
  input  lsbp_pkg::in_item_t            in_item,
  input  logic                          cfg_wr_en,
  input  logic [lsbp_pkg::CAP_W-1:0]    cfg_wr_data,
  output lsbp_pkg::out_item_t           out_item
);
  import lsbp_pkg::*;

  // The capacity register is 17 bits wide, so a larger bound never limits it.
  localparam int unsigned CAP_MAX   = (1 << CAP_W) - 1;
  localparam int unsigned MAX_CLAMP = (MAX_WORDS > CAP_MAX) ? CAP_MAX : MAX_WORDS;
  localparam logic [CAP_W-1:0] MAX_WORDS_CAP = CAP_W'(MAX_CLAMP);

  in_item_t            item_q;
  logic [FWIDTH_W-1:0] add_q;
  logic [WORD_W-1:0]   bits_q;
  logic [CAP_W-1:0]    capacity;
  logic [WORD_W-1:0]   scratch;
  logic [PEND_W-1:0]   pending;
  logic [NWP_W-1:0]    next_word_position;
  logic [TOTAL_W-1:0]  accepted_bits;

  logic [FWIDTH_W-1:0] add_next;
  logic [WORD_W-1:0]   bits_next;
  logic [FWIDTH_W-1:0] fw_sat;
  logic [FWIDTH_W-1:0] mult_sat;
  logic [FWIDTH_W-1:0] rem;

  logic [CAP_W-1:0]    cap_eff;
  logic [TOTAL_W-1:0]  cap_bits;
  logic [TOTAL_W:0]    acc_sum;
  logic                overflow;
  logic [2*WORD_W-1:0] merged;
  logic [FWIDTH_W:0]   pend_sum;
  logic [WORD_W-1:0]   low_word;
  out_item_t           out_item_next;

  // First step: width saturation, field mask and the padding for an align or flush item.
  always_comb begin
    fw_sat    = (item_q.field_width > FWIDTH_W'(WORD_W)) ?
                FWIDTH_W'(WORD_W) : item_q.field_width;
    mult_sat  = (item_q.align_multiple == '0) ? FWIDTH_W'(1) :
                (item_q.align_multiple > FWIDTH_W'(WORD_W)) ? FWIDTH_W'(WORD_W) :
                item_q.align_multiple;
    // Restoring remainder of the pending count by the boundary, one bit a step.
    rem = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      rem = {rem[FWIDTH_W-2:0], pending[i]};
      if (rem >= mult_sat) rem = rem - mult_sat;
    end
    add_next  = '0;
    bits_next = '0;
    case (item_q.kind)
      KIND_WRITE: begin
        add_next = fw_sat;
        if (fw_sat != '0) begin
          bits_next = item_q.field_value &
                      ({WORD_W{1'b1}} >> (FWIDTH_W'(WORD_W) - fw_sat));
        end
      end
      KIND_ALIGN: begin
        add_next = (rem == '0) ? '0 : (mult_sat - rem);
      end
      KIND_FLUSH: begin
        add_next = (pending == '0) ? '0 : (FWIDTH_W'(WORD_W) - {1'b0, pending});
      end
      default: begin
        add_next = '0;
      end
    endcase
  end

  // Second step: capacity check and merging the new bits above the pending ones.
  always_comb begin
    cap_eff  = (capacity > MAX_WORDS_CAP) ? MAX_WORDS_CAP : capacity;
    cap_bits = {cap_eff, 5'b0};
    acc_sum  = {1'b0, accepted_bits} + (TOTAL_W+1)'(add_q);
    overflow = (add_q != '0) && (acc_sum > {1'b0, cap_bits});
    merged   = {{WORD_W{1'b0}}, scratch} | ({{WORD_W{1'b0}}, bits_q} << pending);
    pend_sum = {2'b0, pending} + {1'b0, add_q};
    low_word = merged[WORD_W-1:0];
  end

  // Input capture and first-step registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) item_q <= in_item;
    if (cmd.calc_en) begin
      add_q  <= add_next;
      bits_q <= bits_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Packer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scratch            <= '0;
      pending            <= '0;
      next_word_position <= '0;
      accepted_bits      <= '0;
    end else if (cmd.apply_en && (add_q != '0) && !overflow) begin
      accepted_bits <= acc_sum[TOTAL_W-1:0];
      if (pend_sum[FWIDTH_W-1]) begin
        scratch            <= merged[2*WORD_W-1:WORD_W];
        pending            <= pend_sum[PEND_W-1:0];
        next_word_position <= next_word_position + NWP_W'(1);
      end else begin
        scratch <= low_word;
        pending <= pend_sum[PEND_W-1:0];
      end
    end
  end

  // Result of the item being applied.
  always_comb begin
    out_item_next                = '0;
    out_item_next.overflow_error = overflow;
    out_item_next.total_bits     = accepted_bits;
    if ((add_q != '0) && !overflow) begin
      out_item_next.total_bits = acc_sum[TOTAL_W-1:0];
      if (pend_sum[FWIDTH_W-1]) begin
        out_item_next.word_valid    = 1'b1;
        out_item_next.packed_word   = {low_word[7:0], low_word[15:8],
                                       low_word[23:16], low_word[31:24]};
        out_item_next.word_position = next_word_position[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_en) out_item <= out_item_next;
  end

endmodule

[rtl/lsb_first_bit_packer.sv]
// Top level of the LSB-first bit packer: controller plus datapath.
//
// Input items (in_valid/in_stall, payload in_item) carry one of three kinds:
// write a field of 1 to 32 bits, pad with zeros to a bit boundary, or flush
// a partial word. Bits stack least significant first above the pending bits.
// Every item gives exactly one result item on out_valid/out_stall (payload
// out_item): a completed 32-bit word in big-endian byte order with its word
// index when one is finished, the overflow flag when the item was dropped for
// lack of capacity, and the running total of accepted bits.
// The input item is registered, then one step computes the bit count to add
// (including the remainder of the pending count by the align boundary), and the
// next updates the scratch register and loads the output register. A new item
// is taken during the second step of the previous one, unless the output stalls.
// A new item is taken while a finished result waits in the output register;
// if the receiver stalls, the block holds its result and stops taking items
// once a second result is ready to be stored.
// The capacity register (cfg_wr_en/cfg_wr_data) is to be written by the user while idle; the block does not enforce it.
// Synchronous reset clears the packer state, empties the output register and
// sets the capacity to 256 words.
module lsb_first_bit_packer #(
  parameter int unsigned MAX_WORDS = lsbp_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lsbp_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lsbp_pkg::out_item_t        out_item,
  input  logic                       cfg_wr_en,
  input  logic [lsbp_pkg::CAP_W-1:0] cfg_wr_data
);
  import lsbp_pkg::*;

  lsbp_cmd_t cmd;

  // Sequencing and handshake control.
  lsbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Bit packing datapath.
  lsbp_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_item    (out_item)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the LSB-first bit packer: random and directed items with prediction.
module tb_top;
  import lsbp_pkg::*;

  // Kind code that the block treats as no operation.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTED = 40;

  // Tracks the packer state and holds the words it should produce, oldest first.
  class packer_scoreboard;
    logic [63:0] scratch;
    int unsigned pend_bits;
    int unsigned word_index;
    int unsigned bit_total;
    int unsigned cap_words;
    out_item_t predicted_words[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      scratch = '0;
      pend_bits = 0;
      word_index = 0;
      bit_total = 0;
      cap_words = CAP_RESET;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] words);
      cap_words = words;
    endfunction

    function int unsigned outstanding();
      return predicted_words.size();
    endfunction

    // Applies one accepted item to the packer state and queues the result it causes.
    function void pack_item(in_item_t it);
      int unsigned add;
      int unsigned width;
      int unsigned boundary;
      longint unsigned room;
      logic [63:0] bits;
      logic [31:0] low_word;
      out_item_t exp_word;
      add = 0;
      bits = '0;
      exp_word = '0;
      case (it.kind)
        KIND_WRITE: begin
          width = (it.field_width > 32) ? 32 : it.field_width;
          add = width;
          if (width != 0) begin
            bits = {32'd0, it.field_value} & ((64'd1 << width) - 64'd1);
          end
        end
        KIND_ALIGN: begin
          boundary = it.align_multiple;
          if (boundary == 0) boundary = 1;
          if (boundary > 32) boundary = 32;
          add = (boundary - (pend_bits % boundary)) % boundary;
        end
        KIND_FLUSH: begin
          if (pend_bits != 0) add = 32 - pend_bits;
        end
        default: begin
        end
      endcase
      // Effective capacity saturates at the largest buffer the block supports.
      room = ((cap_words > MAX_WORDS_DEFAULT) ? MAX_WORDS_DEFAULT : cap_words);
      room = room * 32;
      if (add > 0) begin
        if (longint'(bit_total) + add > room) begin
          exp_word.overflow_error = 1'b1;
        end else begin
          scratch = scratch | (bits << pend_bits);
          pend_bits = pend_bits + add;
          bit_total = bit_total + add;
          if (pend_bits >= 32) begin
            low_word = scratch[31:0];
            exp_word.word_valid = 1'b1;
            exp_word.packed_word = {low_word[7:0], low_word[15:8], low_word[23:16],
                                    low_word[31:24]};
            exp_word.word_position = word_index[POS_W-1:0];
            scratch = scratch >> 32;
            pend_bits = pend_bits - 32;
            word_index = (word_index + 1) & 32'h1FFFF;
          end
        end
      end
      exp_word.total_bits = bit_total[TOTAL_W-1:0];
      predicted_words.push_back(exp_word);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < MAX_PRINTED) begin
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h", results_seen, what,
                 got, want);
      end
      mismatches++;
    endtask

    // Compares one accepted result with the oldest prediction, field by field.
    task check_word(out_item_t got);
      out_item_t want;
      results_seen++;
      if (predicted_words.size() == 0) begin
        report_mismatch("result with nothing predicted", got.packed_word, 0);
      end else begin
        want = predicted_words.pop_front();
        if (got.word_valid !== want.word_valid)
          report_mismatch("word_valid", got.word_valid, want.word_valid);
        if (got.packed_word !== want.packed_word)
          report_mismatch("packed_word", got.packed_word, want.packed_word);
        if (got.word_position !== want.word_position)
          report_mismatch("word_position", got.word_position, want.word_position);
        if (got.overflow_error !== want.overflow_error)
          report_mismatch("overflow_error", got.overflow_error, want.overflow_error);
        if (got.total_bits !== want.total_bits)
          report_mismatch("total_bits", got.total_bits, want.total_bits);
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  packer_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit gaps_on = 1'b1;

  lsb_first_bit_packer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock with a period of 8.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Observe accepted items on both channels.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.pack_item(in_item);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(out_item);
  end

  // Receiver: random stalls of varied length, plus one long hold-off mid-run.
  initial begin
    int unsigned pick;
    int unsigned len;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sb.results_seen >= 120) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 60);
        end else if (pick < 92) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offers one item after a random idle gap, which may be zero; valid stays high when the next item follows at once.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind, input logic [31:0] value,
                             input logic [5:0] width, input logic [5:0] boundary);
    in_item_t it;
    it.kind = kind;
    it.field_value = value;
    it.field_width = width;
    it.align_multiple = boundary;
    send_item(it);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] words);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= words;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(words);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.field_value = $urandom();
    it.field_width = ($urandom_range(0, 99) < 8) ? FWIDTH_W'($urandom_range(0, 63)) :
                     FWIDTH_W'($urandom_range(1, 32));
    it.align_multiple = ($urandom_range(0, 99) < 40) ? 6'd8 :
                        FWIDTH_W'($urandom_range(0, 63));
    if (pick < 62) it.kind = KIND_WRITE;
    else if (pick < 80) it.kind = KIND_ALIGN;
    else if (pick < 93) it.kind = KIND_FLUSH;
    else it.kind = KIND_NONE;
    return it;
  endfunction

  // Random phase; every offered item counts toward the total, no-operation items included.
  task automatic send_random(input int unsigned count);
    in_item_t it;
    int unsigned done_items;
    done_items = 0;
    while (done_items < count) begin
      if (done_items % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      it = random_item();
      send_item(it);
      done_items++;
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence: reset, directed cases, then random phases over several capacities.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases under the reset capacity.
    send_fields(KIND_WRITE, 32'h0000_0001, 6'd1, 6'd8);
    send_fields(KIND_WRITE, 32'hFFFF_FFFF, 6'd32, 6'd8);
    send_fields(KIND_WRITE, 32'h0000_FFFF, 6'd0, 6'd8);
    send_fields(KIND_WRITE, 32'hA5A5_5A5A, 6'd63, 6'd8);
    send_fields(KIND_WRITE, 32'hFFFF_FFE0, 6'd5, 6'd8);
    send_fields(KIND_ALIGN, 32'hFFFF_FFFF, 6'd63, 6'd8);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd8);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd0);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd63);
    send_fields(KIND_NONE, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_fields(KIND_FLUSH, 32'hFFFF_FFFF, 6'd32, 6'd32);
    send_fields(KIND_WRITE, 32'h0000_0ABC, 6'd12, 6'd8);
    send_fields(KIND_FLUSH, 32'h0, 6'd0, 6'd0);
    send_fields(KIND_WRITE, 32'h7FFF_FFFF, 6'd31, 6'd8);
    send_fields(KIND_WRITE, 32'h0000_0001, 6'd1, 6'd8);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd1);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd32);
    send_fields(KIND_WRITE, 32'h0000_0055, 6'd7, 6'd8);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd3);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd5);
    send_fields(KIND_FLUSH, 32'h0, 6'd1, 6'd8);
    drain();

    // Zero capacity: every item that adds bits is dropped.
    write_capacity('0);
    send_fields(KIND_WRITE, 32'h1, 6'd1, 6'd8);
    send_fields(KIND_WRITE, 32'hFFFF_FFFF, 6'd32, 6'd8);
    send_fields(KIND_ALIGN, 32'h0, 6'd1, 6'd8);
    send_fields(KIND_FLUSH, 32'h0, 6'd1, 6'd8);
    drain();
    write_capacity(17'd1);
    send_fields(KIND_WRITE, 32'h3, 6'd2, 6'd8);
    drain();

    // Largest register value, which saturates to the block maximum.
    write_capacity(17'h1FFFF);
    send_random(200);
    drain();

    // Capacity only a few words above what is already used.
    write_capacity(CAP_W'(sb.word_index + 3));
    send_random(60);
    drain();

    write_capacity(CAP_W'(MAX_WORDS_DEFAULT));
    send_random(100);
    drain();

    write_capacity(CAP_W'(sb.word_index + 10));
    send_random(80);
    drain();

    write_capacity(CAP_RESET);
    send_random(85);
    drain();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[lsb_first_bit_packer.f]
rtl/lsbp_pkg.sv
rtl/lsbp_ctrl.sv
rtl/lsbp_datapath.sv
rtl/lsb_first_bit_packer.sv
bench/tb_top.sv
